// File: design/fwpk_pkg.sv
// Shared types and command codes for the byte queue with purge by key.
package fwpk_pkg;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_PURGE = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] value;
    } t_req;

    typedef struct packed {
        logic [4:0] fill_count;
        logic [7:0] front_byte;
        logic       front_valid;
        logic       push_dropped;
        logic [4:0] purged_count;
    } t_rsp;

endpackage

// File: design/fwpk_chan_if.sv
// Valid/ready channel interface carrying one request or result per handshake.
interface fwpk_chan_if #(
    parameter type T_DATA = logic
);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/fwpk_ram.sv
// Entry store: one write port, one read port with registered read data.
module fwpk_ram #(
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/fwpk_ctrl.sv
// Sequencer: ring pointers, purge compaction pass, front readback, result register.
module fwpk_ctrl #(
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fwpk_chan_if.sink     i_req,
    fwpk_chan_if.source   o_rsp,
    output logic          o_ram_we,
    output logic [AW-1:0] o_ram_waddr,
    output logic [7:0]    o_ram_wdata,
    output logic          o_ram_re,
    output logic [AW-1:0] o_ram_raddr,
    input  logic [7:0]    i_ram_rdata
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FRONT = 4'b0100,
        S_CAPT  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]   r_left, n_left;
    logic            r_pend, n_pend;
    logic [CW-1:0]   r_kept, n_kept;
    logic [CW-1:0]   r_removed, n_removed;
    logic            r_dropped, n_dropped;
    logic [7:0]      r_key, n_key;
    logic            r_out_valid, n_out_valid;
    fwpk_pkg::t_rsp  r_out, n_out;

    logic [AW:0]     w_sum;
    logic [AW:0]     w_tail;
    logic            w_accept;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [4:0] f_low5(input logic [CW-1:0] v);
        logic [CW+4:0] w;
        w = {5'b0, v};
        return w[4:0];
    endfunction

    assign w_accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign w_sum  = {1'b0, r_head} + (AW + 1)'(r_count);
    assign w_tail = (w_sum >= (AW + 1)'(DEPTH)) ? w_sum - (AW + 1)'(DEPTH) : w_sum;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_left      = r_left;
        n_pend      = r_pend;
        n_kept      = r_kept;
        n_removed   = r_removed;
        n_dropped   = r_dropped;
        n_key       = r_key;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_wr_ptr;
        o_ram_wdata = i_ram_rdata;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_rd_ptr;

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key     = i_req.data.value;
                    n_dropped = 1'b0;
                    n_removed = '0;
                    n_state   = S_FRONT;
                    unique case (i_req.data.cmd)
                        fwpk_pkg::CMD_PUSH: begin
                            if (r_count < CW'(DEPTH)) begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = w_tail[AW-1:0];
                                o_ram_wdata = i_req.data.value;
                                n_count     = r_count + 1'b1;
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        fwpk_pkg::CMD_POP: begin
                            if (r_count != '0) begin
                                n_head  = f_inc(r_head);
                                n_count = r_count - 1'b1;
                            end
                        end
                        fwpk_pkg::CMD_PURGE: begin
                            n_rd_ptr = r_head;
                            n_wr_ptr = r_head;
                            n_left   = r_count;
                            n_pend   = 1'b0;
                            n_kept   = '0;
                            n_state  = S_SCAN;
                        end
                        default: begin
                            n_state = S_FRONT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_pend) begin
                    if (i_ram_rdata == r_key) begin
                        n_removed = r_removed + 1'b1;
                    end else begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = r_wr_ptr;
                        o_ram_wdata = i_ram_rdata;
                        n_wr_ptr    = f_inc(r_wr_ptr);
                        n_kept      = r_kept + 1'b1;
                    end
                end
                if (r_left != '0) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_rd_ptr;
                    n_rd_ptr    = f_inc(r_rd_ptr);
                    n_left      = r_left - 1'b1;
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count = r_kept;
                        n_state = S_FRONT;
                    end
                end
            end
            S_FRONT: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = r_head;
                n_state     = S_CAPT;
            end
            S_CAPT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out.fill_count   = f_low5(r_count);
                    n_out.front_valid  = (r_count != '0);
                    n_out.front_byte   = (r_count != '0) ? i_ram_rdata : 8'd0;
                    n_out.push_dropped = r_dropped;
                    n_out.purged_count = f_low5(r_removed);
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_kept      <= '0;
            r_removed   <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_kept      <= n_kept;
            r_removed   <= n_removed;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_out <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("occupancy above store depth");

    a_scan_tally: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((CW + 1)'(r_kept) + (CW + 1)'(r_removed)
            + (CW + 1)'(r_left) + (CW + 1)'(r_pend) == (CW + 1)'(r_count)))
        else $error("purge pass lost track of entries");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.data.cmd == fwpk_pkg::CMD_PUSH) && (r_count < CW'(DEPTH)))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("push into free slot did not grow occupancy");

    a_scan_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram_we && o_ram_re && (r_state == S_SCAN)) |-> (o_ram_waddr != o_ram_raddr))
        else $error("compaction write hit the entry being read");
endmodule

// File: design/fifo_with_purge_by_key.sv
// Top level of the byte queue with purge by key.
//
//   port   | dir | payload          | handshake
//   -------+-----+------------------+-------------------------------
//   i_req  | in  | cmd, value       | valid/ready, one request
//   o_rsp  | out | fill, front, flags | valid/ready, one result
//
// Push, pop and unused commands pass through a front read and a capture state before the
// result is raised, and the next request is taken once the capture is done; a purge first
// runs its compaction pass, one read per held entry plus drain, then front read, capture.
// Synchronous active-low reset empties the queue; store contents are not cleared.
// Requests are taken only while no command is in progress; a finished result
// waits in the output register, and a new request may enter while it waits.
module fifo_with_purge_by_key #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fwpk_chan_if.sink   i_req,
    fwpk_chan_if.source o_rsp
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;

    fwpk_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_ram_we    (w_we),
        .o_ram_waddr (w_waddr),
        .o_ram_wdata (w_wdata),
        .o_ram_re    (w_re),
        .o_ram_raddr (w_raddr),
        .i_ram_rdata (w_rdata)
    );

    fwpk_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );
endmodule

// File: dv/fifo_with_purge_by_key_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the byte queue with purge by key, with its own queue predictor.
module fifo_with_purge_by_key_test;

    localparam int          DEPTH        = 16;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam int          TRAFFIC_ITEMS = 290;

    logic i_clk;
    logic i_rst_n;

    fwpk_chan_if #(.T_DATA(fwpk_pkg::t_req)) req_if ();
    fwpk_chan_if #(.T_DATA(fwpk_pkg::t_rsp)) rsp_if ();

    fifo_with_purge_by_key #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    logic [7:0]     queue_shadow[$];
    fwpk_pkg::t_rsp awaited_status_q[$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int error_count        = 0;
    int cycle_count        = 0;
    int checked_count      = 0;
    int push_count         = 0;
    int pop_count          = 0;
    int purge_count        = 0;
    int unused_count       = 0;
    int drop_count         = 0;
    int purged_total       = 0;
    int full_hits          = 0;
    int empty_pops         = 0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic fwpk_pkg::t_rsp queue_apply(input fwpk_pkg::t_req rq);
        fwpk_pkg::t_rsp st;
        logic [7:0]     kept[$];
        int             removed;
        st = '0;
        removed = 0;
        case (rq.cmd)
            fwpk_pkg::CMD_PUSH: begin
                if (queue_shadow.size() < DEPTH) begin
                    queue_shadow.push_back(rq.value);
                end else begin
                    st.push_dropped = 1'b1;
                end
            end
            fwpk_pkg::CMD_POP: begin
                if (queue_shadow.size() > 0) begin
                    void'(queue_shadow.pop_front());
                end
            end
            fwpk_pkg::CMD_PURGE: begin
                foreach (queue_shadow[i]) begin
                    if (queue_shadow[i] == rq.value) begin
                        removed++;
                    end else begin
                        kept.push_back(queue_shadow[i]);
                    end
                end
                queue_shadow = kept;
            end
            default: ;
        endcase
        st.fill_count   = 5'(queue_shadow.size());
        st.front_valid  = queue_shadow.size() > 0;
        st.front_byte   = st.front_valid ? queue_shadow[0] : 8'h00;
        st.purged_count = 5'(removed);
        return st;
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic [7:0] value);
        fwpk_pkg::t_req rq;
        fwpk_pkg::t_rsp st;
        rq.cmd   = cmd;
        rq.value = value;
        while ($urandom_range(99) < sender_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.data  = rq;
        req_if.valid = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        case (cmd)
            fwpk_pkg::CMD_PUSH:  push_count++;
            fwpk_pkg::CMD_POP:   pop_count++;
            fwpk_pkg::CMD_PURGE: purge_count++;
            default:             unused_count++;
        endcase
        if (cmd == fwpk_pkg::CMD_POP && queue_shadow.size() == 0) begin
            empty_pops++;
        end
        st = queue_apply(rq);
        if (st.push_dropped) begin
            drop_count++;
        end
        if (st.fill_count == DEPTH) begin
            full_hits++;
        end
        purged_total += st.purged_count;
        awaited_status_q.push_back(st);
        @(negedge i_clk);
    endtask

    task automatic check_status(input fwpk_pkg::t_rsp got);
        fwpk_pkg::t_rsp exp;
        if (awaited_status_q.size() == 0) begin
            $error("unexpected result: fill_count %0d front_byte %0h", got.fill_count,
                   got.front_byte);
            error_count++;
            return;
        end
        exp = awaited_status_q.pop_front();
        checked_count++;
        if (got.fill_count !== exp.fill_count) begin
            $error("fill_count: expected %0d, actual %0d", exp.fill_count, got.fill_count);
            error_count++;
        end
        if (got.front_byte !== exp.front_byte) begin
            $error("front_byte: expected %0h, actual %0h", exp.front_byte, got.front_byte);
            error_count++;
        end
        if (got.front_valid !== exp.front_valid) begin
            $error("front_valid: expected %0b, actual %0b", exp.front_valid, got.front_valid);
            error_count++;
        end
        if (got.push_dropped !== exp.push_dropped) begin
            $error("push_dropped: expected %0b, actual %0b", exp.push_dropped,
                   got.push_dropped);
            error_count++;
        end
        if (got.purged_count !== exp.purged_count) begin
            $error("purged_count: expected %0d, actual %0d", exp.purged_count,
                   got.purged_count);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            check_status(rsp_if.data);
        end
    end

    always @(negedge i_clk) begin
        rsp_if.ready = ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic test_empty_queue_ops();
        send_request(fwpk_pkg::CMD_POP, 8'h00);
        send_request(fwpk_pkg::CMD_PURGE, 8'hFF);
        send_request(CMD_UNUSED, 8'hFF);
    endtask

    task automatic test_fill_and_overflow();
        for (int i = 0; i < DEPTH; i++) begin
            send_request(fwpk_pkg::CMD_PUSH, i[0] ? 8'h00 : 8'hFF);
        end
        send_request(fwpk_pkg::CMD_PUSH, 8'h5A);
        send_request(CMD_UNUSED, 8'h00);
    endtask

    task automatic test_purge_and_pop();
        send_request(fwpk_pkg::CMD_PURGE, 8'hFF);
        send_request(fwpk_pkg::CMD_PURGE, 8'h5A);
        send_request(fwpk_pkg::CMD_POP, 8'hFF);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        int         done;
        int         mode;
        int         burst;
        int         pick;
        int         push_pct;
        int         pop_pct;
        logic [7:0] key_base;
        logic [1:0] cmd;
        logic [7:0] value;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        done = 0;
        while (done < n_items) begin
            mode     = $urandom_range(2);
            burst    = $urandom_range(8, 30);
            key_base = 8'($urandom);
            push_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
            pop_pct  = (mode == 0) ? 10 : (mode == 1) ? 45 : 25;
            for (int b = 0; b < burst && done < n_items; b++) begin
                pick = $urandom_range(99);
                if (pick < push_pct) begin
                    cmd = fwpk_pkg::CMD_PUSH;
                end else if (pick < push_pct + pop_pct) begin
                    cmd = fwpk_pkg::CMD_POP;
                end else if (pick < 97) begin
                    cmd = fwpk_pkg::CMD_PURGE;
                end else begin
                    cmd = CMD_UNUSED;
                end
                if ($urandom_range(99) < 70) begin
                    value = key_base + 8'($urandom_range(3));
                end else begin
                    value = 8'($urandom);
                end
                done++;
                send_request(cmd, value);
            end
        end
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_queue_ops();
        test_fill_and_overflow();
        test_purge_and_pop();
        test_random_traffic(0, 0, TRAFFIC_ITEMS);
        test_random_traffic(65, 0, TRAFFIC_ITEMS);
        test_random_traffic(0, 65, TRAFFIC_ITEMS);
        test_random_traffic(23, 23, TRAFFIC_ITEMS);

        req_if.valid = 1'b0;
        while (awaited_status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d results: %0d push, %0d pop (%0d on empty), %0d purge, %0d unused",
                 checked_count, push_count, pop_count, empty_pops, purge_count, unused_count);
        $display("queue full %0d times, %0d pushes dropped, %0d entries purged, %0d errors",
                 full_hits, drop_count, purged_total, error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
